/* rtl/ppm_pkg.sv */
// package: sizes, codes, state type and controller/datapath structs for the page map
`timescale 1ns / 1ps
package ppm_pkg;

    localparam int SLOTS      = 64;
    localparam int PAGE_WORDS = 64;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int PMEM_D  = SLOTS * PAGE_WORDS;
    localparam int PA_W    = $clog2(PMEM_D);
    localparam int KIND_W  = 2;
    localparam int PID_W   = 32;
    localparam int OFF_W   = 16;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DATA = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_DRAIN,
        ST_LOOKUP,
        ST_ACCESS,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic probe;
        logic lookup;
        logic access;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic probe_last;
        logic op_ok;
    } t_status;

endpackage

/* rtl/ppm_in_if.sv */
// interface: input item channel
`timescale 1ns / 1ps
interface ppm_in_if
    import ppm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [PID_W-1:0]         pid;
    logic [OFF_W-1:0]         offset;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, kind, pid, offset, value, input ready);
    modport sink   (input valid, kind, pid, offset, value, output ready);
endinterface

/* rtl/ppm_out_if.sv */
// interface: result item channel
`timescale 1ns / 1ps
interface ppm_out_if
    import ppm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [OFF_W-1:0]         echo_offset;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, status, echo_offset, read_value, input ready);
    modport sink   (input valid, status, echo_offset, read_value, output ready);
endinterface

/* rtl/ppm_ram.sv */
// generic ram: one write port, one read port, registered read data
`timescale 1ns / 1ps
module ppm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/ppm_ctrl.sv */
// controller: sequences clear, probe, lookup, access and result hand-off
`timescale 1ns / 1ps
module ppm_ctrl
    import ppm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PROBE;
                end
            end
            ST_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_status.probe_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = i_status.op_ok ? ST_ACCESS : ST_FINISH;
            end
            ST_ACCESS: begin
                o_cmd.access = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_accept_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == ST_PROBE))
        else $error("accepted item did not start a probe");
    a_lookup_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP) |-> ($past(r_state) == ST_DRAIN))
        else $error("lookup entered without draining the compare stage");
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("result load did not raise valid");
endmodule

/* rtl/ppm_dp.sv */
// datapath: slot table, free page stack, page memory and result register
`timescale 1ns / 1ps
module ppm_dp
    import ppm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [PID_W-1:0]         i_pid,
    input  logic [OFF_W-1:0]         i_offset,
    input  logic signed [DATA_W-1:0] i_value,
    output logic [STAT_W-1:0]        o_status_code,
    output logic [OFF_W-1:0]         o_echo_offset,
    output logic signed [DATA_W-1:0] o_read_value
);
    // latched item
    logic [KIND_W-1:0] r_kind;
    logic [PID_W-1:0]  r_pid;
    logic [OFF_W-1:0]  r_offset;
    logic [DATA_W-1:0] r_value;

    // probe walk and compare stage
    logic [SLOT_W-1:0] r_pos, r_step, r_cnt;
    logic              r_p_vld, r_p_used;
    logic [SLOT_W-1:0] r_p_pos;
    logic              r_found, r_efound, r_ok;
    logic [SLOT_W-1:0] r_fslot, r_eslot;

    logic [SLOTS-1:0]  r_used;
    logic [SLOTS-1:0]  r_free_vld;
    logic [CNT_W-1:0]  r_free_cnt;
    logic              r_fr_vld;
    logic [SLOT_W-1:0] r_fr_idx;
    logic [PA_W-1:0]   r_clr;

    logic [PID_W-1:0]  key_rdata;
    logic [SLOT_W-1:0] page_rdata, free_rdata, free_page, acc_page;
    logic [DATA_W-1:0] pmem_rdata;
    logic [SLOT_W-1:0] free_top;
    logic              op_ok, off_ok, push_ok;

    logic [STAT_W-1:0] r_o_stat;
    logic [OFF_W-1:0]  r_o_echo;
    logic [DATA_W-1:0] r_o_data;

    logic              pm_we;
    logic [PA_W-1:0]   pm_waddr, acc_addr;
    logic [DATA_W-1:0] pm_wdata;

    assign free_top  = SLOT_W'(r_free_cnt - CNT_W'(1));
    assign free_page = r_fr_vld ? free_rdata : r_fr_idx;
    assign acc_page  = (r_kind == KIND_INSERT) ? free_page : page_rdata;
    assign off_ok    = {1'b0, r_offset} < (OFF_W + 1)'(PAGE_WORDS);
    assign push_ok   = r_free_cnt < CNT_W'(SLOTS);
    assign acc_addr  = PA_W'(PA_W'(acc_page) * PA_W'(PAGE_WORDS) + PA_W'(r_offset));

    always_comb begin
        case (r_kind)
            KIND_INSERT: op_ok = !r_found && (r_free_cnt != '0) && r_efound;
            KIND_DELETE: op_ok = r_found;
            default:     op_ok = r_found && off_ok;
        endcase
    end

    assign o_status.op_ok      = op_ok;
    assign o_status.probe_last = (r_cnt == SLOT_W'(SLOTS - 1));
    assign o_status.clear_done = (r_clr == PA_W'(PMEM_D - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_free_vld <= '0;
            r_free_cnt <= CNT_W'(SLOTS);
            r_clr      <= '0;
            r_p_vld    <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.probe;
            if (i_cmd.clear) begin
                r_clr <= r_clr + PA_W'(1);
            end
            if (i_cmd.access) begin
                if (r_kind == KIND_INSERT) begin
                    r_used[r_eslot] <= 1'b1;
                    r_free_cnt      <= r_free_cnt - CNT_W'(1);
                end else if (r_kind == KIND_DELETE) begin
                    r_used[r_fslot] <= 1'b0;
                    if (push_ok) begin
                        r_free_vld[SLOT_W'(r_free_cnt)] <= 1'b1;
                        r_free_cnt <= r_free_cnt + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= i_kind;
            r_pid    <= i_pid;
            r_offset <= i_offset;
            r_value  <= i_value;
            r_pos    <= i_pid[SLOT_W-1:0];
            r_step   <= i_pid[2*SLOT_W-1:SLOT_W] | SLOT_W'(1);
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_efound <= 1'b0;
        end
        if (i_cmd.probe) begin
            r_p_pos  <= r_pos;
            r_p_used <= r_used[r_pos];
            r_pos    <= r_pos + r_step;
            r_cnt    <= r_cnt + SLOT_W'(1);
        end
        // first hit and first empty slot in probe order
        if (r_p_vld) begin
            if (r_p_used && key_rdata == r_pid && !r_found) begin
                r_found <= 1'b1;
                r_fslot <= r_p_pos;
            end
            if (!r_p_used && !r_efound) begin
                r_efound <= 1'b1;
                r_eslot  <= r_p_pos;
            end
        end
        if (i_cmd.lookup) begin
            r_ok     <= op_ok;
            r_fr_idx <= free_top;
            r_fr_vld <= r_free_vld[free_top];
        end
        if (i_cmd.finish) begin
            if (!r_ok) begin
                r_o_stat <= STAT_FAIL;
                r_o_echo <= '0;
                r_o_data <= '0;
            end else if (r_kind == KIND_READ) begin
                r_o_stat <= STAT_DATA;
                r_o_echo <= r_offset;
                r_o_data <= pmem_rdata;
            end else begin
                r_o_stat <= STAT_OK;
                r_o_echo <= '0;
                r_o_data <= '0;
            end
        end
    end

    ppm_ram #(.WIDTH(PID_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.access && r_kind == KIND_INSERT),
        .i_waddr (r_eslot),
        .i_wdata (r_pid),
        .i_re    (i_cmd.probe),
        .i_raddr (r_pos),
        .o_rdata (key_rdata)
    );

    ppm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.access && r_kind == KIND_INSERT),
        .i_waddr (r_eslot),
        .i_wdata (free_page),
        .i_re    (i_cmd.lookup),
        .i_raddr (r_fslot),
        .o_rdata (page_rdata)
    );

    ppm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.access && r_kind == KIND_DELETE && push_ok),
        .i_waddr (SLOT_W'(r_free_cnt)),
        .i_wdata (page_rdata),
        .i_re    (i_cmd.lookup),
        .i_raddr (free_top),
        .o_rdata (free_rdata)
    );

    always_comb begin
        pm_we    = 1'b0;
        pm_waddr = acc_addr;
        pm_wdata = r_value;
        if (i_cmd.clear) begin
            pm_we    = 1'b1;
            pm_waddr = r_clr;
            pm_wdata = '0;
        end else if (i_cmd.access && r_kind == KIND_WRITE) begin
            pm_we = 1'b1;
        end
    end

    ppm_ram #(.WIDTH(DATA_W), .DEPTH(PMEM_D)) u_page_mem (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_re    (i_cmd.access && r_kind == KIND_READ),
        .i_raddr (acc_addr),
        .o_rdata (pmem_rdata)
    );

    assign o_status_code = r_o_stat;
    assign o_echo_offset = r_o_echo;
    assign o_read_value  = r_o_data;
endmodule

/* rtl/process_page_map_double_hash_core.sv */
// top level: process id to page map with a double-hashed slot table
// order from accept to result valid: each slot is probed in turn, then drain, lookup,
//   access (skipped when the item fails) and finish, which waits while the last result is unread
// items are not overlapped: a new item is accepted only once finish has returned to idle
// reset: synchronous active low; afterwards the page memory is zeroed one word
//   per cycle, all SLOTS*PAGE_WORDS words (4096), with in.ready low meanwhile
`timescale 1ns / 1ps
module process_page_map_double_hash_core
    import ppm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppm_in_if.sink    i_in,
    ppm_out_if.source o_out
);
    // command and status between controller and datapath
    t_cmd    cmd;
    t_status status;

    // controller owns both handshakes and the walk order
    ppm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath holds the tables, free stack, page memory and result register
    ppm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_kind        (i_in.kind),
        .i_pid         (i_in.pid),
        .i_offset      (i_in.offset),
        .i_value       (i_in.value),
        .o_status_code (o_out.status),
        .o_echo_offset (o_out.echo_offset),
        .o_read_value  (o_out.read_value)
    );
endmodule

/* bench/ppm_checker.sv */
// checker: watches both channels, predicts each result from the page map state and compares
`timescale 1ns / 1ps
module ppm_checker
    import ppm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppm_in_if         i_in,
    ppm_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [OFF_W-1:0]         echo_offset;
        logic signed [DATA_W-1:0] read_value;
    } t_result;

    logic                 map_used [SLOTS];
    logic [PID_W-1:0]     map_key  [SLOTS];
    logic [SLOT_W-1:0]    map_page [SLOTS];
    logic [SLOT_W-1:0]    free_stack [SLOTS];
    int                   free_top;
    logic [DATA_W-1:0]    page_mem [PMEM_D];
    t_result              pending_results [$];

    function automatic int slot_at(logic [PID_W-1:0] pid, int i);
        int home;
        int stride;
        home   = pid % SLOTS;
        stride = (pid / SLOTS) % SLOTS;
        if (stride % 2 == 0) stride = stride + 1;
        return (home + i * stride) % SLOTS;
    endfunction

    function automatic int locate_pid(logic [PID_W-1:0] pid);
        int s;
        for (int i = 0; i < SLOTS; i++) begin
            s = slot_at(pid, i);
            if (map_used[s] && map_key[s] == pid) return s;
        end
        return -1;
    endfunction

    function automatic int first_free_slot(logic [PID_W-1:0] pid);
        int s;
        for (int i = 0; i < SLOTS; i++) begin
            s = slot_at(pid, i);
            if (!map_used[s]) return s;
        end
        return -1;
    endfunction

    task automatic apply_op(logic [KIND_W-1:0] kind, logic [PID_W-1:0] pid,
                            logic [OFF_W-1:0] offset, logic [DATA_W-1:0] value);
        t_result r;
        int s;
        int addr;
        r = '{STAT_FAIL, '0, '0};
        case (kind)
            KIND_INSERT: begin
                if (locate_pid(pid) < 0 && free_top > 0) begin
                    s = first_free_slot(pid);
                    if (s >= 0) begin
                        free_top--;
                        map_used[s] = 1'b1;
                        map_key[s]  = pid;
                        map_page[s] = free_stack[free_top];
                        r.status    = STAT_OK;
                    end
                end
            end
            KIND_DELETE: begin
                s = locate_pid(pid);
                if (s >= 0) begin
                    if (free_top < SLOTS) begin
                        free_stack[free_top] = map_page[s];
                        free_top++;
                    end
                    map_used[s] = 1'b0;
                    r.status    = STAT_OK;
                end
            end
            default: begin
                s = locate_pid(pid);
                if (s >= 0 && offset < PAGE_WORDS) begin
                    addr = map_page[s] * PAGE_WORDS + offset;
                    if (kind == KIND_READ) begin
                        r.status      = STAT_DATA;
                        r.echo_offset = offset;
                        r.read_value  = page_mem[addr];
                    end else begin
                        page_mem[addr] = value;
                        r.status       = STAT_OK;
                    end
                end
            end
        endcase
        pending_results = {pending_results, r};
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            map_used[i]   = 1'b0;
            map_key[i]    = '0;
            map_page[i]   = '0;
            free_stack[i] = SLOT_W'(i);
        end
        for (int i = 0; i < PMEM_D; i++) page_mem[i] = '0;
        free_top     = SLOTS;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: status %0d", i_out.status);
                end else begin
                    want = pending_results.pop_front();
                    if (want.status !== i_out.status
                        || want.echo_offset !== i_out.echo_offset
                        || want.read_value !== i_out.read_value) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %0d/%0d/%h got %0d/%0d/%h",
                                     want.status, want.echo_offset, want.read_value,
                                     i_out.status, i_out.echo_offset, i_out.read_value);
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                apply_op(i_in.kind, i_in.pid, i_in.offset, i_in.value);
            o_pending <= pending_results.size();
        end
    end

endmodule

/* bench/process_page_map_double_hash_core_tb.sv */
// testbench top: stimulus, idling profiles, watchdog and verdict for the page map
`timescale 1ns / 1ps
module process_page_map_double_hash_core_tb;
    import ppm_pkg::*;

    localparam int LATENCY   = SLOTS + 4;
    localparam int WATCHDOG  = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 30;
    int   recv_idle_pct = 46;
    bit   recv_hold = 1'b0;
    int   idle_cycles = 0;
    logic [PID_W-1:0] live_pids [$];

    ppm_in_if  in_ch ();
    ppm_out_if out_ch ();

    process_page_map_double_hash_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    ppm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.kind   = '0;
        in_ch.pid    = '0;
        in_ch.offset = '0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
    end

    // receiver: random stalls, or a long hold-off while recv_hold is set
    always @(posedge i_clk) begin
        out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    // offer one item and hold it until accepted, idling beforehand at random
    task automatic send_op(logic [KIND_W-1:0] kind, logic [PID_W-1:0] pid,
                           logic [OFF_W-1:0] offset, logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.kind   <= kind;
        in_ch.pid    <= pid;
        in_ch.offset <= offset;
        in_ch.value  <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // pid: random, small, or an earlier inserted one, so that probe chains collide often
    function automatic logic [PID_W-1:0] pick_pid();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(255);
            default: begin
                if (live_pids.size() != 0)
                    return live_pids[$urandom_range(live_pids.size() - 1)];
                return $urandom();
            end
        endcase
    endfunction

    task automatic random_op();
        logic [KIND_W-1:0] kind;
        logic [PID_W-1:0]  pid;
        logic [OFF_W-1:0]  offset;
        kind = KIND_W'($urandom_range(3));
        pid  = pick_pid();
        offset = ($urandom_range(9) == 0) ? OFF_W'($urandom())
                                          : OFF_W'($urandom_range(PAGE_WORDS - 1));
        if (kind == KIND_INSERT && live_pids.size() < 80) live_pids = {live_pids, pid};
        send_op(kind, pid, offset, $urandom());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, absent pids, bad offsets
        send_op(KIND_READ, 32'd5, 16'd0, '0);
        send_op(KIND_INSERT, 32'd0, 16'd0, '0);
        send_op(KIND_INSERT, 32'd0, 16'd0, '0);
        send_op(KIND_INSERT, 32'hFFFF_FFFF, 16'd0, '0);
        send_op(KIND_INSERT, 32'd64, 16'd0, '0);
        send_op(KIND_WRITE, 32'hFFFF_FFFF, 16'd63, 32'h8000_0000);
        send_op(KIND_WRITE, 32'd0, 16'd0, 32'h7FFF_FFFF);
        send_op(KIND_WRITE, 32'd0, 16'd64, 32'hFFFF_FFFF);
        send_op(KIND_WRITE, 32'd0, 16'hFFFF, 32'h1234_5678);
        send_op(KIND_READ, 32'hFFFF_FFFF, 16'd63, '0);
        send_op(KIND_READ, 32'd0, 16'd0, '0);
        send_op(KIND_READ, 32'd0, 16'hFFFF, '0);
        send_op(KIND_READ, 32'd64, 16'd1, '0);
        send_op(KIND_DELETE, 32'd0, 16'd0, '0);
        send_op(KIND_DELETE, 32'd0, 16'd0, '0);
        send_op(KIND_READ, 32'd0, 16'd0, '0);
        send_op(KIND_WRITE, 32'd7, 16'd0, '0);
        send_op(KIND_DELETE, 32'hFFFF_FFFF, 16'd0, '0);
        send_op(KIND_DELETE, 32'd64, 16'd0, '0);
        drain_results();

        // fill the table past capacity, then empty it
        for (int i = 0; i < SLOTS + 2; i++) send_op(KIND_INSERT, PID_W'(i * 3), 16'd0, '0);
        for (int i = 0; i < SLOTS + 2; i++) send_op(KIND_DELETE, PID_W'(i * 3), 16'd0, '0);
        drain_results();

        // receiver holds off long while the sender keeps offering
        fork
            begin
                recv_hold = 1'b1;
                repeat (600) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++) random_op();
        join
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 30 : 0;
            for (int i = 0; i < 350; i++) random_op();
            drain_results();
        end

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/ppm_pkg.sv
rtl/ppm_in_if.sv
rtl/ppm_out_if.sv
rtl/ppm_ram.sv
rtl/ppm_ctrl.sv
rtl/ppm_dp.sv
rtl/process_page_map_double_hash_core.sv
bench/ppm_checker.sv
bench/process_page_map_double_hash_core_tb.sv
